FILE: src/plig_pkg.sv
// Shared types and constants for the particle integrator with gradient lookup.
package plig_pkg;

	localparam int TIME_W = 16;
	localparam int NORM_W = 17;
	localparam int VEC_W  = 48;
	localparam int COMP_W = 16;
	localparam int MUL_W  = 17;
	localparam int PROD_W = 2 * MUL_W;
	localparam int CFG_W  = 4;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [0:0] REG_COLOR_KEY_COUNT = 1'd0;
	localparam logic [0:0] REG_SCALE_KEY_COUNT = 1'd1;

	localparam logic [NORM_W-1:0] NORM_ONE = 17'h10000;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] life_time;
		logic [VEC_W-1:0]  start_position;
		logic [VEC_W-1:0]  start_velocity;
		logic [VEC_W-1:0]  start_accel;
		logic [15:0]       base_scale;
		logic [TIME_W-1:0] delta_time;
		logic [2:0]        key_index;
		logic [31:0]       key_color;
		logic [15:0]       key_scale;
	} in_item_t;

	typedef struct packed {
		logic [VEC_W-1:0] vertex_position;
		logic [31:0]      vertex_color;
		logic [15:0]      vertex_size;
		logic             alive;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_DIV,
		ST_GRAD,
		ST_KP,
		ST_KP_WB,
		ST_RD0,
		ST_RD1,
		ST_LERP,
		ST_LERP_WB,
		ST_ENDCAP,
		ST_SIZE,
		ST_SIZE_WB,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MOP_POS,
		MOP_VEL,
		MOP_KP_S,
		MOP_KP_C,
		MOP_LERP_S,
		MOP_LERP_C,
		MOP_SIZE
	} mul_op_t;

	typedef struct packed {
		logic    valid;
		mul_op_t op;
		logic [1:0] comp;
	} mul_tag_t;

	typedef struct packed {
		mul_tag_t                 tag;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		mul_tag_t                 tag;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

FILE: src/particle_life_integrate_gradient.sv
// Top level: one particle, Euler integration and color/scale gradient lookup per item.
//
//   channel  | signals                      | transfer when
//   ---------+------------------------------+-------------------------------
//   input    | in_valid, in_ready, in_data  | in_valid && in_ready
//   output   | out_valid, out_ready, out_data | out_valid && out_ready
//   config   | cfg_we, cfg_index, cfg_data  | cfg_we (no wait)
//
// Sequence: a tick of a live particle first starts the 16-step divider that forms
// normalized time; it holds the sequencer, and the six position/velocity products
// run through the shared multiplier while it works. The gradient then issues two key
// position products, two key reads, five lerp products and one size product when it
// interpolates, and reads the end keys and issues only the size product when time
// sits at 0 or 1. Any other item goes straight to the gradient. Reset clears the
// particle state and sets both key counts to 2; the key store is not cleared.
// A result waits in the output register while the next item is taken; the block
// stalls only if that item finishes before the result is taken.
module particle_life_integrate_gradient #(
	parameter int MAX_KEYS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  plig_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output plig_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [plig_pkg::CFG_W-1:0]  cfg_data
);

	import plig_pkg::*;

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam logic [2:0] TICK_OPS  = 3'd6;
	localparam logic [2:0] LERP_LAST = 3'd4;

	// clamp a configured key count into the usable range
	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
		if (c < CFG_W'(2)) begin
			return CNT_W'(2);
		end else if (int'(c) > MAX_KEYS) begin
			return CNT_W'(MAX_KEYS);
		end else begin
			return CNT_W'(c);
		end
	endfunction

	// saturate a two's complement sum to the signed 16-bit range
	function automatic logic [COMP_W-1:0] sat16(input logic [26:0] v);
		if (!v[26] && (|v[25:15])) begin
			return 16'h7FFF;
		end else if (v[26] && !(&v[25:15])) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	logic [CFG_W-1:0]  color_cnt_q;
	logic [CFG_W-1:0]  scale_cnt_q;
	logic [CNT_W-1:0]  cc;
	logic [CNT_W-1:0]  sc;
	logic [IDX_W-1:0]  last_c;
	logic [IDX_W-1:0]  last_s;

	logic              live_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] total_q;
	logic [NORM_W-1:0] norm_q;
	logic [VEC_W-1:0]  pos_q;
	logic [VEC_W-1:0]  vel_q;
	logic [VEC_W-1:0]  acc_q;
	logic [15:0]       scale_q;
	logic [TIME_W-1:0] dt_q;

	logic [IDX_W-1:0]  idx_s_q;
	logic [IDX_W-1:0]  idx_c_q;
	logic [15:0]       f_s_q;
	logic [15:0]       f_c_q;
	logic [15:0]       a_s_q;
	logic [31:0]       a_c_q;
	logic [15:0]       s_q;
	logic [31:0]       color_q;
	logic [15:0]       size_q;

	logic              in_fire;
	logic              out_load;
	logic              norm_load;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              div_start;
	logic              div_busy;
	logic [TIME_W-1:0] div_quo;

	mul_req_t          mreq;
	mul_rsp_t          mrsp;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh8;
	logic [26:0]       pv_sum;
	logic [23:0]       size_full;

	logic              key_we;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx_c;
	logic [IDX_W-1:0]  rd_idx_s;
	logic [31:0]       rd_color;
	logic [15:0]       rd_scale;

	logic [1:0]        ch;
	logic [8:0]        dch;
	logic [TIME_W:0]   elapsed_sum;

	assign cc     = eff_count(color_cnt_q);
	assign sc     = eff_count(scale_cnt_q);
	assign last_c = IDX_W'(cc - CNT_W'(1));
	assign last_s = IDX_W'(sc - CNT_W'(1));

	assign in_fire = in_valid && in_ready;
	assign key_we  = in_fire && (in_data.mode == MODE_LOAD) &&
		(int'(in_data.key_index) < MAX_KEYS);

	assign ch  = 2'(cnt_q - 3'd1);
	assign dch = {1'b0, rd_color[8*ch +: 8]} - {1'b0, a_c_q[8*ch +: 8]};

	plig_keys #(.MAX_KEYS(MAX_KEYS)) u_keys (
		.clk      (clk),
		.wr_en    (key_we),
		.wr_idx   (IDX_W'(in_data.key_index)),
		.wr_color (in_data.key_color),
		.wr_scale (in_data.key_scale),
		.rd_en    (rd_en),
		.rd_idx_c (rd_idx_c),
		.rd_idx_s (rd_idx_s),
		.rd_color (rd_color),
		.rd_scale (rd_scale)
	);

	plig_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	plig_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_q),
		.divisor  (total_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// sequencer: next state, multiplier issue, key reads, divider start
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		norm_load = 1'b0;
		out_load  = 1'b0;
		rd_en     = 1'b0;
		rd_idx_c  = '0;
		rd_idx_s  = '0;
		mreq      = '0;
		mreq.tag.op = MOP_POS;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					if (in_data.mode == MODE_TICK && live_q) begin
						state_d = ST_TICK;
					end else begin
						state_d = ST_GRAD;
					end
				end
			end
			ST_TICK: begin
				div_start = 1'b1;
				cnt_d     = '0;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				// alternate position and velocity products per component
				if (cnt_q < TICK_OPS) begin
					mreq.tag.valid = 1'b1;
					mreq.tag.comp  = cnt_q[2:1];
					mreq.b         = {1'b0, dt_q};
					if (cnt_q[0]) begin
						mreq.tag.op = MOP_VEL;
						mreq.a = {acc_q[16*cnt_q[2:1] + 15], acc_q[16*cnt_q[2:1] +: 16]};
					end else begin
						mreq.tag.op = MOP_POS;
						mreq.a = {vel_q[16*cnt_q[2:1] + 15], vel_q[16*cnt_q[2:1] +: 16]};
					end
					cnt_d = cnt_q + 3'd1;
				end else if (!div_busy) begin
					norm_load = 1'b1;
					state_d   = ST_GRAD;
				end
			end
			ST_GRAD: begin
				if (norm_q[NORM_W-1] || norm_q == '0) begin
					rd_en    = 1'b1;
					rd_idx_c = norm_q[NORM_W-1] ? last_c : '0;
					rd_idx_s = norm_q[NORM_W-1] ? last_s : '0;
					state_d  = ST_ENDCAP;
				end else begin
					mreq.tag.valid = 1'b1;
					mreq.tag.op    = MOP_KP_S;
					mreq.a         = {1'b0, norm_q[15:0]};
					mreq.b         = MUL_W'(sc - CNT_W'(1));
					state_d        = ST_KP;
				end
			end
			ST_KP: begin
				mreq.tag.valid = 1'b1;
				mreq.tag.op    = MOP_KP_C;
				mreq.a         = {1'b0, norm_q[15:0]};
				mreq.b         = MUL_W'(cc - CNT_W'(1));
				state_d        = ST_KP_WB;
			end
			ST_KP_WB: begin
				state_d = ST_RD0;
			end
			ST_RD0: begin
				rd_en    = 1'b1;
				rd_idx_c = idx_c_q;
				rd_idx_s = idx_s_q;
				state_d  = ST_RD1;
			end
			ST_RD1: begin
				rd_en    = 1'b1;
				rd_idx_c = IDX_W'(idx_c_q + 1'b1);
				rd_idx_s = IDX_W'(idx_s_q + 1'b1);
				cnt_d    = '0;
				state_d  = ST_LERP;
			end
			ST_LERP: begin
				mreq.tag.valid = 1'b1;
				if (cnt_q == '0) begin
					mreq.tag.op = MOP_LERP_S;
					mreq.a      = {1'b0, rd_scale} - {1'b0, a_s_q};
					mreq.b      = {1'b0, f_s_q};
				end else begin
					mreq.tag.op   = MOP_LERP_C;
					mreq.tag.comp = ch;
					mreq.a        = {{(MUL_W - 9){dch[8]}}, dch};
					mreq.b        = {1'b0, f_c_q};
				end
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == LERP_LAST) begin
					state_d = ST_LERP_WB;
				end
			end
			ST_LERP_WB: begin
				state_d = ST_SIZE;
			end
			ST_ENDCAP: begin
				state_d = ST_SIZE;
			end
			ST_SIZE: begin
				mreq.tag.valid = 1'b1;
				mreq.tag.op    = MOP_SIZE;
				mreq.a         = {1'b0, scale_q};
				mreq.b         = {1'b0, s_q};
				state_d        = ST_SIZE_WB;
			end
			ST_SIZE_WB: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// key count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_cnt_q <= CFG_W'(2);
			scale_cnt_q <= CFG_W'(2);
		end else if (cfg_we) begin
			if (cfg_index == REG_COLOR_KEY_COUNT) begin
				color_cnt_q <= cfg_data;
			end
			if (cfg_index == REG_SCALE_KEY_COUNT) begin
				scale_cnt_q <= cfg_data;
			end
		end
	end

	assign prod        = mrsp.prod;
	assign prod_sh8    = prod >>> 8;
	assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, in_data.delta_time};
	assign size_full   = prod[31:8];

	always_comb begin
		if (mrsp.tag.op == MOP_POS) begin
			pv_sum = {{11{pos_q[16*mrsp.tag.comp + 15]}}, pos_q[16*mrsp.tag.comp +: 16]} +
				prod_sh8[26:0];
		end else begin
			pv_sum = {{11{vel_q[16*mrsp.tag.comp + 15]}}, vel_q[16*mrsp.tag.comp +: 16]} +
				prod_sh8[26:0];
		end
	end

	// particle state: start, tick bookkeeping and integration write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= 1'b0;
			elapsed_q <= '0;
			total_q   <= TIME_W'(1);
			norm_q    <= '0;
			pos_q     <= '0;
			vel_q     <= '0;
			acc_q     <= '0;
			scale_q   <= '0;
		end else begin
			if (in_fire && in_data.mode == MODE_START) begin
				live_q    <= 1'b1;
				total_q   <= in_data.life_time;
				elapsed_q <= '0;
				norm_q    <= '0;
				pos_q     <= in_data.start_position;
				vel_q     <= in_data.start_velocity;
				acc_q     <= in_data.start_accel;
				scale_q   <= in_data.base_scale;
			end
			if (in_fire && in_data.mode == MODE_TICK && live_q) begin
				// expiry looks at the elapsed time before this step
				live_q    <= elapsed_q < total_q;
				elapsed_q <= elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
			end
			if (norm_load) begin
				if (total_q == '0 || elapsed_q >= total_q) begin
					norm_q <= NORM_ONE;
				end else begin
					norm_q <= {1'b0, div_quo};
				end
			end
			if (mrsp.tag.valid && mrsp.tag.op == MOP_POS) begin
				pos_q[16*mrsp.tag.comp +: 16] <= sat16(pv_sum);
			end
			if (mrsp.tag.valid && mrsp.tag.op == MOP_VEL) begin
				vel_q[16*mrsp.tag.comp +: 16] <= sat16(pv_sum);
			end
		end
	end

	// gradient datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dt_q <= in_data.delta_time;
		end
		if (state_q == ST_RD1) begin
			a_s_q <= rd_scale;
			a_c_q <= rd_color;
		end
		if (state_q == ST_ENDCAP) begin
			s_q     <= rd_scale;
			color_q <= rd_color;
		end
		if (mrsp.tag.valid) begin
			case (mrsp.tag.op)
				MOP_KP_S: begin
					idx_s_q <= prod[16 +: IDX_W];
					f_s_q   <= prod[15:0];
				end
				MOP_KP_C: begin
					idx_c_q <= prod[16 +: IDX_W];
					f_c_q   <= prod[15:0];
				end
				MOP_LERP_S: begin
					s_q <= a_s_q + prod[31:16];
				end
				MOP_LERP_C: begin
					color_q[8*mrsp.tag.comp +: 8] <= a_c_q[8*mrsp.tag.comp +: 8] +
						prod[23:16];
				end
				MOP_SIZE: begin
					size_q <= (|size_full[23:16]) ? 16'hFFFF : size_full[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.vertex_position <= pos_q;
			out_q.vertex_color    <= color_q;
			out_q.vertex_size     <= size_q;
			out_q.alive           <= live_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("input taken while divider busy");

	a_mul_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.tag.valid |-> (state_q != ST_IDLE && state_q != ST_OUT))
		else $error("multiplier result with no sequence running");

	a_dead_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.mode == MODE_TICK && !live_q) |=> state_q == ST_GRAD)
		else $error("tick of dead particle entered integration");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm_q[NORM_W-1] |-> norm_q[NORM_W-2:0] == '0)
		else $error("normalized time above one");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

FILE: src/plig_keys.sv
// Color and scale gradient key storage, one write port and one registered read port each.
module plig_keys #(
	parameter int MAX_KEYS = 8,
	localparam int IDX_W = $clog2(MAX_KEYS)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [31:0]      wr_color,
	input  logic [15:0]      wr_scale,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx_c,
	input  logic [IDX_W-1:0] rd_idx_s,
	output logic [31:0]      rd_color,
	output logic [15:0]      rd_scale
);

	logic [31:0] color_mem [MAX_KEYS];
	logic [15:0] scale_mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			color_mem[wr_idx] <= wr_color;
			scale_mem[wr_idx] <= wr_scale;
		end
	end

	// hold the read data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_color <= color_mem[rd_idx_c];
			rd_scale <= scale_mem[rd_idx_s];
		end
	end

endmodule

FILE: src/plig_mul.sv
// Shared signed 17x17 multiplier with a registered product and operation tag.
module plig_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  plig_pkg::mul_req_t req,
	output plig_pkg::mul_rsp_t rsp
);

	import plig_pkg::*;

	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [PROD_W-1:0] prod_s1;
	mul_tag_t                 tag_s1;

	assign op_a = req.a;
	assign op_b = req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= req.tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign rsp.tag  = tag_s1;
	assign rsp.prod = prod_s1;

endmodule

FILE: src/plig_div.sv
// Restoring divider, one quotient bit per cycle, for the normalized lifetime.
module plig_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plig_pkg::TIME_W-1:0] dividend,
	input  logic [plig_pkg::TIME_W-1:0] divisor,
	output logic                        busy,
	output logic [plig_pkg::TIME_W-1:0] quotient
);

	import plig_pkg::*;

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [TIME_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, divisor};
	assign busy  = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(TIME_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, divisor}) : trial[TIME_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

FILE: sim/particle_life_integrate_gradient_test.sv
// Self-checking testbench for the particle integrator with color and scale gradients.
`timescale 1ns / 100ps

module particle_life_integrate_gradient_test;
	import plig_pkg::*;

	localparam int KEY_SLOTS = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [CFG_W-1:0] cfg_data;

	particle_life_integrate_gradient #(
		.MAX_KEYS(KEY_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Particle state as the block should hold it, updated at each input transfer.
	logic        live_q = 1'b0;
	logic [15:0] elapsed_q = '0;
	logic [15:0] total_q = 16'd1;
	logic [16:0] norm_q = '0;
	logic [47:0] pos_q = '0;
	logic [47:0] vel_q = '0;
	logic [47:0] acc_q = '0;
	logic [15:0] scale_q = '0;
	logic [31:0] color_key_q [KEY_SLOTS];
	logic [15:0] scale_key_q [KEY_SLOTS];
	logic [3:0]  color_count_q = 4'd2;
	logic [3:0]  scale_count_q = 4'd2;

	out_item_t vertex_expected [$];
	out_item_t vertex_want;

	int  sent_items = 0;
	int  checked_vertices = 0;
	int  mismatch_count = 0;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;
	int  hold_request = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int used_keys(input logic [3:0] c);
		if (c < 2) return 2;
		if (c > KEY_SLOTS) return KEY_SLOTS;
		return int'(c);
	endfunction

	function automatic logic [15:0] sat_comp(input longint x);
		if (x > 32767) return 16'h7FFF;
		if (x < -32768) return 16'h8000;
		return x[15:0];
	endfunction

	// a + floor((b - a) * f / 65536); >>> on a signed longint rounds toward minus infinity
	function automatic longint blend(input longint a, input longint b, input longint f);
		return a + (((b - a) * f) >>> 16);
	endfunction

	// Locate the pair of keys around normalized time and the fraction between them.
	function automatic void key_slot(input int count, output int idx, output longint frac);
		longint p;
		p = longint'(norm_q) * (count - 1);
		idx = int'(p >>> 16);
		frac = p & 64'hFFFF;
		if (idx > count - 2) begin
			idx = count - 2;
			frac = 64'hFFFF;
		end
	endfunction

	// Apply one input item to the particle and return the vertex it produces.
	function automatic out_item_t advance_particle(input in_item_t it);
		out_item_t v;
		int cc;
		int sc;
		int e;
		int idx;
		longint frac;
		longint sz;
		logic signed [15:0] p;
		logic signed [15:0] vl;
		logic signed [15:0] a;
		logic [31:0] ca;
		logic [31:0] cb;
		logic [15:0] s;

		case (it.mode)
		MODE_LOAD: begin
			color_key_q[it.key_index] = it.key_color;
			scale_key_q[it.key_index] = it.key_scale;
		end
		MODE_START: begin
			live_q = 1'b1;
			total_q = it.life_time;
			elapsed_q = '0;
			norm_q = '0;
			pos_q = it.start_position;
			vel_q = it.start_velocity;
			acc_q = it.start_accel;
			scale_q = it.base_scale;
		end
		MODE_TICK: begin
			if (live_q) begin
				// expiry looks at the elapsed time from before this step
				if (elapsed_q >= total_q) live_q = 1'b0;
				e = int'(elapsed_q) + int'(it.delta_time);
				if (e > 65535) e = 65535;
				elapsed_q = e[15:0];
				if (total_q == 0 || elapsed_q >= total_q) begin
					norm_q = NORM_ONE;
				end else begin
					norm_q = {elapsed_q, 16'h0000} / total_q;
				end
				for (int k = 0; k < 3; k++) begin
					p = pos_q[16*k +: 16];
					vl = vel_q[16*k +: 16];
					a = acc_q[16*k +: 16];
					pos_q[16*k +: 16] = sat_comp(longint'(p) +
						((longint'(vl) * longint'(it.delta_time)) >>> 8));
					vel_q[16*k +: 16] = sat_comp(longint'(vl) +
						((longint'(a) * longint'(it.delta_time)) >>> 8));
				end
			end
		end
		default: ;
		endcase

		cc = used_keys(color_count_q);
		sc = used_keys(scale_count_q);
		if (norm_q >= NORM_ONE) begin
			v.vertex_color = color_key_q[cc-1];
			s = scale_key_q[sc-1];
		end else if (norm_q == 0) begin
			v.vertex_color = color_key_q[0];
			s = scale_key_q[0];
		end else begin
			key_slot(sc, idx, frac);
			s = 16'(blend(scale_key_q[idx], scale_key_q[idx+1], frac));
			key_slot(cc, idx, frac);
			ca = color_key_q[idx];
			cb = color_key_q[idx+1];
			for (int k = 0; k < 4; k++) begin
				v.vertex_color[8*k +: 8] = 8'(blend(ca[8*k +: 8], cb[8*k +: 8], frac));
			end
		end
		sz = (longint'(scale_q) * longint'(s)) >>> 8;
		if (sz > 65535) sz = 65535;
		v.vertex_size = sz[15:0];
		v.vertex_position = pos_q;
		v.alive = live_q;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Every field but the mode random, so each other bit toggles regardless of mode.
	function automatic in_item_t random_item(input logic [1:0] mode);
		logic [255:0] raw;
		in_item_t it;
		raw = {$urandom, $urandom, $urandom, $urandom,
		       $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.mode = mode;
		return it;
	endfunction

	// Three small signed components, so motion builds up over many ticks.
	function automatic logic [47:0] small_vec();
		logic [47:0] v;
		for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(0, 1023) - 512);
		return v;
	endfunction

	// Offer one item, hold it until the transfer, record the vertex it must produce.
	task automatic send_item(input in_item_t it);
		int gap;
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		vertex_expected.push_back(advance_particle(it));
		sent_items++;
		gap = gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid and hold until every pending vertex has come back.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (vertex_expected.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_COLOR_KEY_COUNT) color_count_q = val;
		else scale_count_q = val;
	endtask

	// Only call with the block idle.
	task automatic set_key_counts(input logic [3:0] colors, input logic [3:0] scales);
		write_reg(REG_COLOR_KEY_COUNT, colors);
		write_reg(REG_SCALE_KEY_COUNT, scales);
	endtask

	// One particle from start until it has died or max_ticks ticks are sent, with queries and key loads mixed in.
	task automatic run_particle(input int max_ticks);
		in_item_t it;
		logic [15:0] dt;
		int ticks;
		int life;

		case ($urandom_range(0, 9))
		0: dt = 16'($urandom);
		1: dt = '0;
		default: dt = 16'($urandom_range(1, 384));
		endcase
		it = random_item(MODE_START);
		case ($urandom_range(0, 9))
		0: it.life_time = '0;
		1: it.life_time = 16'($urandom);
		default: begin
			life = int'(dt) * $urandom_range(1, 12) + $urandom_range(0, 255);
			it.life_time = (life > 65535) ? 16'hFFFF : 16'(life);
		end
		endcase
		if ($urandom_range(0, 1)) it.start_velocity = small_vec();
		if ($urandom_range(0, 1)) it.start_accel = small_vec();
		if ($urandom_range(0, 3) == 0) it.start_position = small_vec();
		send_item(it);

		ticks = 0;
		while (live_q && ticks < max_ticks) begin
			case ($urandom_range(0, 9))
			0: it = random_item(MODE_QUERY);
			1: it = random_item(MODE_LOAD);
			default: begin
				it = random_item(MODE_TICK);
				if ($urandom_range(0, 7) != 0) it.delta_time = dt;
				ticks++;
			end
			endcase
			send_item(it);
		end
		// ticks on the dead particle must leave it alone
		repeat ($urandom_range(0, 2)) send_item(random_item(MODE_TICK));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Fill every key slot (slot 0 first, since each vertex reads it) and look at the
	// reset vertex: no motion, not alive, first keys.
	task automatic test_reset_state();
		in_item_t it;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			it = random_item(MODE_LOAD);
			it.key_index = 3'(i);
			if (i == 0) begin
				it.key_color = 32'hFF00_FF00;
				it.key_scale = 16'hFFFF;
			end else if (i == 1) begin
				it.key_color = 32'h00FF_00FF;
				it.key_scale = 16'h0000;
			end
			send_item(it);
		end
		send_item(random_item(MODE_QUERY));
		send_item(random_item(MODE_TICK));
	endtask

	// Field extremes, zero lifetime, saturation both ways, expiry one tick late.
	task automatic test_edge_cases();
		in_item_t it;

		// zero lifetime: time sits at one, the first tick expires it and still moves it
		it = random_item(MODE_START);
		it.life_time = '0;
		it.base_scale = 16'hFFFF;
		it.start_position = 48'h7FFF_7FFF_7FFF;
		it.start_velocity = 48'h7FFF_7FFF_7FFF;
		it.start_accel = 48'h7FFF_7FFF_7FFF;
		send_item(it);
		it = random_item(MODE_TICK);
		it.delta_time = 16'hFFFF;
		send_item(it);
		send_item(random_item(MODE_TICK));
		send_item(random_item(MODE_QUERY));

		// four-second life in one-second steps: quarters between the keys, then
		// time reaches one and the next tick expires it; negative saturation
		it = random_item(MODE_START);
		it.life_time = 16'h0400;
		it.base_scale = 16'h0100;
		it.start_position = 48'h8000_8000_8000;
		it.start_velocity = 48'h8000_8000_8000;
		it.start_accel = 48'h8000_8000_8000;
		send_item(it);
		repeat (5) begin
			it = random_item(MODE_TICK);
			it.delta_time = 16'h0100;
			send_item(it);
		end

		// longest life: a zero step, then the largest step saturates elapsed time
		it = random_item(MODE_START);
		it.life_time = 16'hFFFF;
		send_item(it);
		it = random_item(MODE_TICK);
		it.delta_time = '0;
		send_item(it);
		it.delta_time = 16'hFFFF;
		send_item(it);
	endtask

	// Key counts below, inside and above the usable range.
	task automatic test_key_count_sweep();
		logic [3:0] color_list [8];
		logic [3:0] scale_list [8];
		color_list = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd3, 4'd9, 4'd5};
		scale_list = '{4'd15, 4'd0, 4'd8, 4'd2, 4'd1, 4'd7, 4'd4, 4'd12};
		for (int i = 0; i < 8; i++) begin
			wait_results();
			set_key_counts(color_list[i], scale_list[i]);
			repeat (3) run_particle(25);
		end
	endtask

	// Bulk of the run: particle lives with random content, some noise, and a
	// full pause with new key counts every few hundred items.
	task automatic test_random_lives(input int count);
		int target;
		int next_pause;
		target = sent_items + count;
		next_pause = sent_items + 300;
		while (sent_items < target) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 4)) send_item(random_item(2'($urandom)));
			end else begin
				run_particle(30);
			end
			if (sent_items >= next_pause) begin
				wait_results();
				set_key_counts(4'($urandom), 4'($urandom));
				next_pause += 300;
			end
		end
	endtask

	// Hold the output off for a long stretch while items keep coming, so the
	// block fills and stops taking input.
	task automatic test_output_backpressure();
		wait_results();
		gaps_on = 1'b0;
		hold_request = 300;
		run_particle(16);
		repeat (6) send_item(random_item(MODE_TICK));
		gaps_on = 1'b1;
	endtask

	// No gaps and no stalls: items and results back to back.
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		repeat (8) run_particle(20);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t: vertex %0d %s: got %0h, want %0h",
				$realtime, checked_vertices, what, got, want);
	endtask

	// Ready drops for random stretches; a long hold-off request wins over them.
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (stalls_on) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (vertex_expected.size() == 0) begin
				report_mismatch("arrived with nothing pending",
					64'(out_data.vertex_position), '0);
			end else begin
				vertex_want = vertex_expected.pop_front();
				if (out_data.vertex_position !== vertex_want.vertex_position)
					report_mismatch("position", 64'(out_data.vertex_position),
						64'(vertex_want.vertex_position));
				if (out_data.vertex_color !== vertex_want.vertex_color)
					report_mismatch("color", 64'(out_data.vertex_color),
						64'(vertex_want.vertex_color));
				if (out_data.vertex_size !== vertex_want.vertex_size)
					report_mismatch("size", 64'(out_data.vertex_size),
						64'(vertex_want.vertex_size));
				if (out_data.alive !== vertex_want.alive)
					report_mismatch("alive", 64'(out_data.alive), 64'(vertex_want.alive));
			end
			checked_vertices++;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_edge_cases();
		test_key_count_sweep();
		test_random_lives(750);
		test_output_backpressure();
		test_random_lives(500);
		test_back_to_back();

		// let the last results come back, then watch for strays
		wait_results();
		repeat (80) @(negedge clk);

		$display("covered %0d items, %0d vertices checked, %0d mismatches", sent_items,
			checked_vertices, mismatch_count);
		$display("  key counts 0..15, zero and full lifetimes, saturation, late expiry");
		if (mismatch_count == 0 && vertex_expected.size() == 0) begin
			$display("[particle_life_integrate_gradient] OK");
		end else begin
			$display("[particle_life_integrate_gradient] ERROR");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#15_000_000;
		$display("timeout with %0d vertices pending", vertex_expected.size());
		$display("[particle_life_integrate_gradient] ERROR");
		$finish;
	end

endmodule
